// ===== rtl/sfp_pkg.sv =====
`default_nettype none
package sfp_pkg;
  localparam int MaxLeaves = 32;
  localparam int NodeCap   = 2 * MaxLeaves - 1;
  localparam int NodeIdxW  = $clog2(NodeCap);
  localparam int StackW    = $clog2(MaxLeaves);
  localparam int CountW    = $clog2(NodeCap + 1);
  localparam int DepthW    = $clog2(MaxLeaves + 1);
  localparam int CoordW    = 23;
  localparam int DataW     = 16;

  localparam logic [1:0] KindLeaf = 2'd0;
  localparam logic [1:0] KindH    = 2'd1;
  localparam logic [1:0] KindV    = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StMissing  = 2'd1;
  localparam logic [1:0] StTooMany  = 2'd2;
  localparam logic [1:0] StNotTree  = 2'd3;

  localparam logic CfgOriginX = 1'b0;
  localparam logic CfgOriginY = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD, S_CUT_RD, S_CUT_WR, S_ROOT, S_WALK_RD, S_WALK_CH, S_WALK_WR,
    S_EMIT_RD, S_EMIT_OUT, S_ERR_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [DataW-1:0]    ident;
    logic [CoordW-1:0]   w;
    logic [CoordW-1:0]   h;
    logic [NodeIdxW-1:0] lc;
    logic [NodeIdxW-1:0] rc;
  } node_t;
endpackage
`default_nettype wire

// ===== rtl/sfp_in_if.sv =====
`default_nettype none
interface sfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] block_id;
  logic [15:0] block_width;
  logic [15:0] block_height;
  logic        last;
  modport source (output valid, kind, block_id, block_width, block_height, last, input ready);
  modport sink (input valid, kind, block_id, block_width, block_height, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfp_out_if.sv =====
`default_nettype none
interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [22:0] pos_x;
  logic [22:0] pos_y;
  logic [1:0]  status;
  logic        out_last;
  modport source (output valid, out_id, out_width, out_height, pos_x, pos_y, status,
                  out_last, input ready);
  modport sink (input valid, out_id, out_width, out_height, pos_x, pos_y, status,
                out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/slicing_floorplan_packer_core.sv =====
// a cut runs S_CUT_RD then S_CUT_WR (node memory read, then write back); a leaf needs only S_LOAD
// the last item adds S_ROOT and a placement walk of S_WALK_RD, S_WALK_CH, S_WALK_WR per node,
// then S_EMIT_RD and S_EMIT_OUT per node for the in-order emit, plus any output stall
// an erroneous run emits one status transfer via S_ROOT then S_ERR_OUT, after the cut states if any
// leaves back to back while no output is pending, a cut holds off input; one run at a time
// reset (async, active low) clears control state and origins; memories hold garbage until written
`default_nettype none
module slicing_floorplan_packer_core
  import sfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  sfp_in_if.sink          in_if,
  sfp_out_if.source       out_if
);

  // node memory (kind, id, size, children) and position memory
  node_t               node_mem [NodeCap];
  logic [CoordW-1:0]   px_mem   [NodeCap];
  logic [CoordW-1:0]   py_mem   [NodeCap];
  // operand stack, read at top two entries and, for the root, at entry 0
  logic [NodeIdxW-1:0] stk_q    [MaxLeaves];

  state_e state_q, state_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [1:0]          err_q, err_d;
  logic [15:0]         ox_q, oy_q;
  logic [CountW-1:0]   ptr_q, ptr_d;
  logic                lastc_q, lastc_d;
  logic [1:0]          ckind_q, ckind_d;
  // register holding pending output transfer
  logic                ov_q;
  logic [15:0]         oid_q, ow_q, oh_q;
  logic [CoordW-1:0]   ox_r_q, oy_r_q;
  logic [1:0]          ost_q;
  logic                olast_q;

  // memory read port: one address per cycle, registered data
  logic [NodeIdxW-1:0] rd_addr;
  node_t               rd_node_q, rd2_node_q;
  logic [CoordW-1:0]   rd_px_q, rd_py_q;
  // parent data kept while children are read
  node_t               par_q;
  logic [CoordW-1:0]   ppx_q, ppy_q;

  logic acc;
  assign in_if.ready = (state_q == S_LOAD) && !ov_q;
  assign acc = in_if.valid && in_if.ready;

  logic [NodeIdxW-1:0] top1, top2;
  assign top1 = stk_q[StackW'(depth_q - DepthW'(1))];
  assign top2 = stk_q[StackW'(depth_q - DepthW'(2))];

  logic [CountW-1:0] leaves;
  assign leaves = CountW'((7'(cnt_q) + 7'(depth_q)) >> 1);

  // the cut reads left then right child through rd_node_q, rd2_node_q
  // the walk reads only the child size its cut needs: left for V, right for H
  always_comb begin
    unique case (state_q)
      S_CUT_RD:  rd_addr = top1;
      S_WALK_CH: rd_addr = (par_q.kind == KindV) ? par_q.lc : par_q.rc;
      default:   rd_addr = top2;
    endcase
    if (state_q == S_WALK_RD || state_q == S_EMIT_RD || state_q == S_EMIT_OUT)
      rd_addr = NodeIdxW'(ptr_q);
    if (state_q == S_LOAD) rd_addr = top2;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (acc && err_q == StOk &&
            (in_if.kind == KindH || in_if.kind == KindV) && depth_q >= DepthW'(2) &&
            cnt_q < CountW'(NodeCap))
          state_d = S_CUT_RD;
        else if (acc && in_if.last) state_d = S_ROOT;
      end
      S_CUT_RD: state_d = S_CUT_WR;
      S_CUT_WR: state_d = lastc_q ? S_ROOT : S_LOAD;
      S_ROOT: begin
        if (err_q != StOk || depth_q != DepthW'(1)) state_d = S_ERR_OUT;
        else if (cnt_q == '0) state_d = S_LOAD;
        else state_d = S_WALK_RD;
      end
      S_WALK_RD: state_d = S_WALK_CH;
      S_WALK_CH: state_d = S_WALK_WR;
      S_WALK_WR: state_d = (ptr_q == '0) ? S_EMIT_RD : S_WALK_RD;
      S_EMIT_RD: state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (!ov_q) state_d = (ptr_q == cnt_q - CountW'(1)) ? S_LOAD : S_EMIT_RD;
      end
      S_ERR_OUT: if (!ov_q) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  // last leaf index, for out_last
  logic [CountW-1:0] lastleaf_q, lastleaf_d;
  logic [CoordW-1:0] sum_w, sum_h, max_w, max_h;
  assign sum_w = rd2_node_q.w + rd_node_q.w;
  assign sum_h = rd2_node_q.h + rd_node_q.h;
  assign max_w = (rd2_node_q.w > rd_node_q.w) ? rd2_node_q.w : rd_node_q.w;
  assign max_h = (rd2_node_q.h > rd_node_q.h) ? rd2_node_q.h : rd_node_q.h;

  // control datapath
  always_comb begin
    depth_d = depth_q; cnt_d = cnt_q; err_d = err_q; ptr_d = ptr_q;
    lastc_d = lastc_q; ckind_d = ckind_q; lastleaf_d = lastleaf_q;
    unique case (state_q)
      S_LOAD: if (acc) begin
        lastc_d = in_if.last;
        ckind_d = in_if.kind;
        if (err_q == StOk) begin
          if (in_if.kind == KindLeaf) begin
            if (leaves >= CountW'(MaxLeaves) || cnt_q >= CountW'(NodeCap)) err_d = StTooMany;
            else begin
              cnt_d = cnt_q + CountW'(1);
              depth_d = depth_q + DepthW'(1);
              lastleaf_d = cnt_q;
            end
          end else if (in_if.kind == KindH || in_if.kind == KindV) begin
            if (depth_q < DepthW'(2)) err_d = StMissing;
            else if (cnt_q >= CountW'(NodeCap)) err_d = StTooMany;
          end
        end
      end
      S_CUT_WR: begin
        depth_d = depth_q - DepthW'(1);
        cnt_d = cnt_q + CountW'(1);
      end
      S_ROOT: begin
        ptr_d = cnt_q - CountW'(1);
        // an empty run is not one tree either
        if (err_q == StOk && depth_q != DepthW'(1)) err_d = StNotTree;
      end
      S_WALK_WR: ptr_d = (ptr_q == '0) ? '0 : ptr_q - CountW'(1);
      S_EMIT_OUT: if (!ov_q) begin
        ptr_d = ptr_q + CountW'(1);
        if (ptr_q == cnt_q - CountW'(1)) begin
          depth_d = '0; cnt_d = '0; err_d = StOk;
        end
      end
      S_ERR_OUT: if (!ov_q) begin
        depth_d = '0; cnt_d = '0; err_d = StOk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; depth_q <= '0; cnt_q <= '0; err_q <= StOk; ptr_q <= '0;
      lastc_q <= 1'b0; ckind_q <= KindLeaf; lastleaf_q <= '0; ox_q <= '0; oy_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d; depth_q <= depth_d; cnt_q <= cnt_d; err_q <= err_d;
      ptr_q <= ptr_d; lastc_q <= lastc_d; ckind_q <= ckind_d; lastleaf_q <= lastleaf_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgOriginX: ox_q <= cfg_data_i;
          CfgOriginY: oy_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_if.ready) ov_q <= 1'b0;
      if ((state_q == S_EMIT_OUT && !ov_q && rd_node_q.kind == KindLeaf) ||
          (state_q == S_ERR_OUT && !ov_q))
        ov_q <= 1'b1;
    end
  end

  // memories and payload
  always_ff @(posedge clk_i) begin
    rd_node_q <= node_mem[rd_addr];
    rd_px_q   <= px_mem[rd_addr];
    rd_py_q   <= py_mem[rd_addr];
    if (state_q == S_CUT_RD) rd2_node_q <= rd_node_q;
    if (state_q == S_LOAD && acc && err_q == StOk && in_if.kind == KindLeaf &&
        leaves < CountW'(MaxLeaves) && cnt_q < CountW'(NodeCap)) begin
      node_mem[NodeIdxW'(cnt_q)] <= '{KindLeaf, in_if.block_id, CoordW'(in_if.block_width),
                                      CoordW'(in_if.block_height), '0, '0};
      stk_q[StackW'(depth_q)] <= NodeIdxW'(cnt_q);
    end
    if (state_q == S_CUT_WR) begin
      if (ckind_q == KindV)
        node_mem[NodeIdxW'(cnt_q)] <= '{KindV, 16'd0, sum_w, max_h, top2, top1};
      else
        node_mem[NodeIdxW'(cnt_q)] <= '{KindH, 16'd0, max_w, sum_h, top2, top1};
      stk_q[StackW'(depth_q - DepthW'(2))] <= NodeIdxW'(cnt_q);
    end
    if (state_q == S_ROOT) begin
      px_mem[stk_q[0]] <= CoordW'(ox_q);
      py_mem[stk_q[0]] <= CoordW'(oy_q);
    end
    if (state_q == S_WALK_RD) begin
      par_q <= node_mem[NodeIdxW'(ptr_q)];
      ppx_q <= px_mem[NodeIdxW'(ptr_q)];
      ppy_q <= py_mem[NodeIdxW'(ptr_q)];
    end
    // S_WALK_CH places the child sitting at the cut corner while that child's size is read
    if (state_q == S_WALK_CH && par_q.kind != KindLeaf) begin
      if (par_q.kind == KindV) begin
        px_mem[par_q.lc] <= ppx_q;
        py_mem[par_q.lc] <= ppy_q;
      end else begin
        px_mem[par_q.rc] <= ppx_q;
        py_mem[par_q.rc] <= ppy_q;
      end
    end
    if (state_q == S_WALK_WR && par_q.kind == KindV) begin
      px_mem[par_q.rc] <= ppx_q + rd_node_q.w;
      py_mem[par_q.rc] <= ppy_q;
    end
    if (state_q == S_WALK_WR && par_q.kind == KindH) begin
      px_mem[par_q.lc] <= ppx_q;
      py_mem[par_q.lc] <= ppy_q + rd_node_q.h;
    end
    if (state_q == S_EMIT_OUT && !ov_q) begin
      oid_q <= rd_node_q.ident; ow_q <= rd_node_q.w[15:0]; oh_q <= rd_node_q.h[15:0];
      ox_r_q <= rd_px_q; oy_r_q <= rd_py_q; ost_q <= StOk;
      olast_q <= (ptr_q == lastleaf_q);
    end
    if (state_q == S_ERR_OUT && !ov_q) begin
      oid_q <= '0; ow_q <= '0; oh_q <= '0; ox_r_q <= '0; oy_r_q <= '0;
      ost_q <= err_q; olast_q <= 1'b1;
    end
  end

  assign out_if.valid      = ov_q;
  assign out_if.out_id     = oid_q;
  assign out_if.out_width  = ow_q;
  assign out_if.out_height = oh_q;
  assign out_if.pos_x      = ox_r_q;
  assign out_if.pos_y      = oy_r_q;
  assign out_if.status     = ost_q;
  assign out_if.out_last   = olast_q;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |-> !in_if.ready) else $error("input taken while busy");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(MaxLeaves)) else $error("stack overflow");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status != StOk |-> out_if.out_last) else $error("error not last");
`endif

endmodule
`default_nettype wire

// ===== tb/slicing_floorplan_packer_core_tb.sv =====
`timescale 1ns / 100ps
module slicing_floorplan_packer_core_tb;
  import sfp_pkg::*;

  // what the driver pulls off its work list: a floorplan item, a register
  // write, or a hold until every placement has come back
  typedef enum int {EntItem, EntCfg, EntDrain} entry_e;

  typedef struct {
    entry_e      tag;
    logic [1:0]  kind;
    logic [15:0] id;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
    logic        cidx;
    logic [15:0] cdata;
  } work_t;

  typedef struct {
    logic [15:0] id;
    logic [15:0] w;
    logic [15:0] h;
    logic [22:0] x;
    logic [22:0] y;
    logic [1:0]  status;
    logic        last;
  } place_t;

  localparam int SettleCycles = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  sfp_in_if  in_if ();
  sfp_out_if out_if ();

  slicing_floorplan_packer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  work_t  work_q[$];
  place_t placement_q[$];
  int     mismatches;
  int     placements_seen;
  int     error_runs;
  int     items_sent;
  int     cycle_no;

  // shadow copy of the packer tree
  logic [1:0]  tr_kind[NodeCap];
  logic [15:0] tr_ident[NodeCap];
  logic [22:0] tr_w[NodeCap];
  logic [22:0] tr_h[NodeCap];
  logic [5:0]  tr_lc[NodeCap];
  logic [5:0]  tr_rc[NodeCap];
  logic [22:0] tr_px[NodeCap];
  logic [22:0] tr_py[NodeCap];
  logic [5:0]  open_stack[MaxLeaves];
  int          open_depth;
  int          node_total;
  logic [1:0]  run_error;
  logic [15:0] org_x;
  logic [15:0] org_y;

  // close a run: flag an error with one status entry, or place the root, push positions down, list leaves in order
  function automatic void close_run();
    place_t p;
    int     l;
    int     r;
    int     emitted;
    emitted = 0;
    if (run_error == StOk && open_depth != 1) run_error = StNotTree;
    if (run_error != StOk) begin
      p = '{default: '0};
      p.status = run_error;
      p.last = 1'b1;
      placement_q.push_back(p);
      error_runs++;
    end else begin
      tr_px[open_stack[0]] = {7'd0, org_x};
      tr_py[open_stack[0]] = {7'd0, org_y};
      for (int i = node_total - 1; i >= 0; i--) begin
        if (tr_kind[i] != KindLeaf) begin
          l = tr_lc[i];
          r = tr_rc[i];
          if (tr_kind[i] == KindV) begin
            tr_px[l] = tr_px[i];
            tr_py[l] = tr_py[i];
            tr_px[r] = tr_px[i] + tr_w[l];
            tr_py[r] = tr_py[i];
          end else begin
            tr_px[r] = tr_px[i];
            tr_py[r] = tr_py[i];
            tr_px[l] = tr_px[i];
            tr_py[l] = tr_py[i] + tr_h[r];
          end
        end
      end
      for (int i = 0; i < node_total; i++) begin
        if (tr_kind[i] == KindLeaf) begin
          p.id = tr_ident[i];
          p.w = tr_w[i][15:0];
          p.h = tr_h[i][15:0];
          p.x = tr_px[i];
          p.y = tr_py[i];
          p.status = StOk;
          p.last = 1'b0;
          placement_q.push_back(p);
          emitted++;
        end
      end
      if (emitted > 0) placement_q[placement_q.size() - 1].last = 1'b1;
    end
    open_depth = 0;
    node_total = 0;
    run_error = StOk;
  endfunction

  // fold one accepted item into the shadow tree
  function automatic void pack_item(work_t it);
    int n;
    int l;
    int r;
    n = node_total;
    if (run_error == StOk) begin
      if (it.kind == KindLeaf) begin
        if ((node_total + open_depth) / 2 >= MaxLeaves || node_total >= NodeCap) begin
          run_error = StTooMany;
        end else begin
          tr_kind[n] = KindLeaf;
          tr_ident[n] = it.id;
          tr_w[n] = {7'd0, it.w};
          tr_h[n] = {7'd0, it.h};
          node_total++;
          open_stack[open_depth] = 6'(n);
          open_depth++;
        end
      end else if (it.kind == KindH || it.kind == KindV) begin
        if (open_depth < 2) begin
          run_error = StMissing;
        end else if (node_total >= NodeCap) begin
          run_error = StTooMany;
        end else begin
          r = open_stack[open_depth - 1];
          l = open_stack[open_depth - 2];
          open_depth -= 2;
          tr_kind[n] = it.kind;
          tr_ident[n] = '0;
          tr_lc[n] = 6'(l);
          tr_rc[n] = 6'(r);
          if (it.kind == KindV) begin
            tr_w[n] = tr_w[l] + tr_w[r];
            tr_h[n] = (tr_h[l] > tr_h[r]) ? tr_h[l] : tr_h[r];
          end else begin
            tr_h[n] = tr_h[l] + tr_h[r];
            tr_w[n] = (tr_w[l] > tr_w[r]) ? tr_w[l] : tr_w[r];
          end
          node_total++;
          open_stack[open_depth] = 6'(n);
          open_depth++;
        end
      end
    end
    if (it.last) close_run();
  endfunction

  task automatic report_mismatch(input string what, input logic [22:0] got,
                                 input logic [22:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // quiet window: no idling on either side for a while in the middle of the run
  function automatic bit take_gap();
    if (cycle_no > 1000 && cycle_no < 1800) return 1'b0;
    return $urandom_range(99) < 13;
  endfunction

  // driver: one entry at a time from the work list
  int settle;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.kind <= '0;
      in_if.block_id <= '0;
      in_if.block_width <= '0;
      in_if.block_height <= '0;
      in_if.last <= 1'b0;
      cfg_we_i <= 1'b0;
      cfg_idx_i <= '0;
      cfg_data_i <= '0;
      settle = 0;
      cycle_no = 0;
    end else begin
      work_t head;
      bit    fire;
      cycle_no++;
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        pack_item('{EntItem, in_if.kind, in_if.block_id, in_if.block_width,
                    in_if.block_height, in_if.last, 1'b0, 16'd0});
        items_sent++;
      end
      cfg_we_i <= 1'b0;
      if (!in_if.valid || fire) begin
        in_if.valid <= 1'b0;
        if (work_q.size() > 0) begin
          head = work_q[0];
          if (head.tag == EntItem) begin
            settle = 0;
            if (!take_gap()) begin
              in_if.valid <= 1'b1;
              in_if.kind <= head.kind;
              in_if.block_id <= head.id;
              in_if.block_width <= head.w;
              in_if.block_height <= head.h;
              in_if.last <= head.last;
              void'(work_q.pop_front());
            end
          end else begin
            // register writes and drains wait for the block to go quiet
            if (placement_q.size() == 0 && !fire) settle++;
            else settle = 0;
            if (settle >= SettleCycles) begin
              if (head.tag == EntCfg) begin
                cfg_we_i <= 1'b1;
                cfg_idx_i <= head.cidx;
                cfg_data_i <= head.cdata;
                if (head.cidx == CfgOriginX) org_x = head.cdata;
                else org_y = head.cdata;
              end
              settle = 0;
              void'(work_q.pop_front());
            end
          end
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      place_t want;
      out_if.ready <= !take_gap();
      if (out_if.valid && out_if.ready) begin
        placements_seen++;
        if (placement_q.size() == 0) begin
          report_mismatch("unexpected transfer, out_id", out_if.out_id, 23'd0);
        end else begin
          want = placement_q.pop_front();
          if (out_if.out_id !== want.id) report_mismatch("out_id", out_if.out_id, want.id);
          if (out_if.out_width !== want.w) report_mismatch("out_width", out_if.out_width, want.w);
          if (out_if.out_height !== want.h)
            report_mismatch("out_height", out_if.out_height, want.h);
          if (out_if.pos_x !== want.x) report_mismatch("pos_x", out_if.pos_x, want.x);
          if (out_if.pos_y !== want.y) report_mismatch("pos_y", out_if.pos_y, want.y);
          if (out_if.status !== want.status) report_mismatch("status", out_if.status, want.status);
          if (out_if.out_last !== want.last) report_mismatch("out_last", out_if.out_last, want.last);
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] kind, input logic [15:0] id, input logic [15:0] w,
                          input logic [15:0] h, input logic last);
    work_q.push_back('{EntItem, kind, id, w, h, last, 1'b0, 16'd0});
  endtask

  task automatic add_cfg(input logic idx, input logic [15:0] data);
    work_q.push_back('{EntCfg, KindLeaf, 16'd0, 16'd0, 16'd0, 1'b0, idx, data});
  endtask

  function automatic logic [1:0] any_cut();
    return $urandom_range(1) ? KindV : KindH;
  endfunction

  // postorder expression over n leaves; flaw 0 clean, 1 early cut,
  // 2 one cut short (not a single tree), 3 noise items of kind 3 mixed in
  task automatic add_floorplan(input int n, input int flaw);
    int leaves_left;
    int open;
    int total;
    int emitted;
    logic [1:0] k;
    leaves_left = n;
    open = 0;
    total = 2 * n - 1 - (flaw == 2 ? 1 : 0);
    emitted = 0;
    if (flaw == 1) begin
      add_item(any_cut(), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    end
    while (emitted < total) begin
      if (leaves_left > 0 && (open < 2 || $urandom_range(1))) begin
        k = KindLeaf;
        leaves_left--;
        open++;
      end else begin
        k = any_cut();
        open--;
      end
      emitted++;
      if (flaw == 3 && $urandom_range(5) == 0)
        add_item(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      add_item(k, 16'($urandom), 16'($urandom), 16'($urandom), emitted == total);
    end
  endtask

  initial begin
    int n;
    int pick;
    mismatches = 0;
    placements_seen = 0;
    error_runs = 0;
    items_sent = 0;
    open_depth = 0;
    node_total = 0;
    run_error = StOk;
    org_x = '0;
    org_y = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme sizes under both cuts, a single leaf, the missing-operand and
    // not-a-tree error codes, kind 3 noise and an empty run
    add_item(KindLeaf, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_item(KindLeaf, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_item(KindV, 16'h0, 16'h0, 16'h0, 1'b0);
    add_item(KindLeaf, 16'h1234, 16'hFFFF, 16'h0001, 1'b0);
    add_item(KindH, 16'h0, 16'h0, 16'h0, 1'b1);
    add_cfg(CfgOriginX, 16'hFFFF);
    add_cfg(CfgOriginY, 16'hFFFF);
    add_item(KindLeaf, 16'hA5A5, 16'hFFFF, 16'hFFFF, 1'b1);
    add_item(KindLeaf, 16'h0001, 16'h0010, 16'h0020, 1'b0);
    add_item(KindLeaf, 16'h0002, 16'hFFFF, 16'hFFFF, 1'b0);
    add_item(KindH, 16'h0, 16'h0, 16'h0, 1'b1);
    add_item(KindV, 16'h0, 16'h0, 16'h0, 1'b0);
    add_item(KindLeaf, 16'h0003, 16'h0004, 16'h0005, 1'b1);
    add_item(KindLeaf, 16'h0004, 16'h0004, 16'h0005, 1'b0);
    add_item(KindLeaf, 16'h0005, 16'h0004, 16'h0005, 1'b1);
    add_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_item(KindLeaf, 16'h0006, 16'h0007, 16'h0008, 1'b0);
    add_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_item(2'd3, 16'h0, 16'h0, 16'h0, 1'b1);
    work_q.push_back('{EntDrain, KindLeaf, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0});
    add_cfg(CfgOriginX, 16'h0000);
    add_cfg(CfgOriginY, 16'h0000);

    // random: mostly clean floorplans of small size, a few at full size,
    // the rest broken or noisy; new origins now and then
    for (int r = 0; work_q.size() < 420; r++) begin
      pick = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? MaxLeaves : $urandom_range(1, 8);
      if (pick < 70) add_floorplan(n, 0);
      else if (pick < 78) add_floorplan(n, 1);
      else if (pick < 86) add_floorplan(n + 1, 2);
      else if (pick < 95) add_floorplan(n, 3);
      else begin
        // one leaf beyond the limit, cut after every leaf but the first
        add_item(KindLeaf, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        for (int i = 1; i <= MaxLeaves; i++) begin
          add_item(KindLeaf, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
          add_item(any_cut(), 16'h0, 16'h0, 16'h0, i == MaxLeaves);
        end
      end
      if (r % 9 == 8) begin
        add_cfg(CfgOriginX, 16'($urandom));
        add_cfg(CfgOriginY, 16'($urandom));
      end
    end

    // the last item has to be taken before the prediction list can be trusted
    wait (work_q.size() == 0);
    @(posedge clk_i);
    wait (!in_if.valid);
    wait (placement_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d items, %0d placements checked, %0d malformed runs flagged",
             items_sent, placements_seen, error_runs);
    if (mismatches == 0 && placement_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d placements never arrived", mismatches, placement_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d placements outstanding", placement_q.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule
